// ===== sv/pmac_pkg.sv =====
// pmac_pkg: constants, types and codes of the pointer motion acceleration curve
// used by every module of the block; depends on nothing
`default_nettype none

package pmac_pkg;

  localparam int SCALE             = 1000;
  localparam int REASONABLE_LIMIT  = 2000;
  localparam int EXTREME_LIMIT     = 10000;
  localparam int SENS_LIMIT        = 10000;
  localparam int FACTOR_LIMIT      = 5000;
  localparam int CURVE_INPUT_LIMIT = 1000;

  localparam int LIN_STEP     = 5;
  localparam int MILD_DEN     = 10;
  localparam int STRONG_SHIFT = 2;
  localparam int HALF_SCALE   = SCALE / 2;
  localparam int SANE_IN      = 100;
  localparam int SANE_OUT     = 1000;
  localparam int SAT_LIM      = 32767 * SCALE;

  localparam int D_W    = 16;
  localparam int SENS_W = 16;
  localparam int FAC_W  = 16;
  localparam int Q_W    = 15;
  localparam int MAG_W  = $clog2(REASONABLE_LIMIT + 1);
  localparam int SQ_W   = 2 * MAG_W;
  localparam int PROD_W = MAG_W + SENS_W;
  localparam int SAT_W  = $clog2(SAT_LIM + 1);
  localparam int CP_W   = Q_W + FAC_W;

  localparam int DIV_SHIFT = SAT_W;
  localparam int DIV_RECIP = (1 << DIV_SHIFT) / SCALE;
  localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
  localparam int DIVP_W    = SAT_W + RECIP_W;

  localparam int TEN_SHIFT = SQ_W;
  localparam int TEN_RECIP = (1 << TEN_SHIFT) / MILD_DEN;
  localparam int TEN_W     = $clog2(TEN_RECIP + 1);
  localparam int TENP_W    = SQ_W + TEN_W;

  localparam int NSTG   = 9;
  localparam int NREG   = 4;
  localparam int ADDR_W = $clog2(NREG * 4);

  typedef logic [D_W-1:0]    d16_t;
  typedef logic [SENS_W-1:0] sens_t;
  typedef logic [FAC_W-1:0]  fac_t;
  typedef logic [Q_W-1:0]    quo_t;
  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SAT_W-1:0]  sat_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [DIVP_W-1:0] divp_t;
  typedef logic [TENP_W-1:0] tenp_t;

  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_EXTREME = 2'd1,
    ST_PASS    = 2'd2,
    ST_CLAMP   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_LIN    = 2'd0,
    MODE_MILD   = 2'd1,
    MODE_STRONG = 2'd2,
    MODE_ALT    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_BASE_SENS = 2'd0,
    REG_ADJ_SENS  = 2'd1,
    REG_MAX_FAC   = 2'd2,
    REG_MODE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic  bad;
    sens_t adj;
    fac_t  max_add;
    mode_t mode;
  } cfg_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_t;

  typedef struct packed {
    logic    neg;
    mag_t    mag;
    status_t st;
    logic    cw;
    logic    half;
    logic    on;
    quo_t    res;
  } side_t;

endpackage

`default_nettype wire

// ===== sv/pmac_in_if.sv =====
// pmac_in_if: input channel carrying one motion delta per beat
// depends on nothing
`default_nettype none

interface pmac_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] motion_delta;

  modport source (output valid, output motion_delta, input ready);
  modport sink   (input valid, input motion_delta, output ready);
endinterface

`default_nettype wire

// ===== sv/pmac_out_if.sv =====
// pmac_out_if: result channel carrying one scaled delta and status per beat
// depends on nothing
`default_nettype none

interface pmac_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] scaled_delta;
  logic [1:0]         status;

  modport source (output valid, output scaled_delta, output status, input ready);
  modport sink   (input valid, input scaled_delta, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/pointer_motion_accel_curve.sv =====
// pointer_motion_accel_curve: top level of the one-axis pointer acceleration curve
// depends on pmac_pkg, pmac_in_if, pmac_out_if, pmac_cfg, pmac_ctl and pmac_dp
`default_nettype none

// Takes one signed motion delta per beat and returns one scaled delta with a
// status code, one result per input, in order. It accepts a new delta every
// clock cycle unless back-pressure has filled every stage; each result passes
// the nine register stages of the datapath: input decode, sensitivity multiply,
// two stages of divide by scale, curve factor, curve multiply, two more stages
// of divide by scale and the output register. Each stage holds its beat while
// the next stage is full and stalled, so back-pressure on the result side stalls
// nothing but the beats behind a waiting result. The user must write settings
// over the apb port while no beat is in flight; the block does not enforce it.

module pointer_motion_accel_curve (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pmac_in_if.sink                          in_bus,
  pmac_out_if.source                       out_bus,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pmac_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  pmac_pkg::cfg_t    cfg;
  pmac_pkg::pipe_t   pipe;
  pmac_pkg::d16_t    scaled;
  pmac_pkg::status_t st;

  pmac_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pmac_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .out_ready (out_bus.ready),
    .pipe      (pipe)
  );

  pmac_dp u_dp (
    .clk          (clk),
    .pipe         (pipe),
    .cfg          (cfg),
    .motion_delta (in_bus.motion_delta),
    .scaled_delta (scaled),
    .status       (st)
  );

  assign in_bus.ready         = pipe.en[0];
  assign out_bus.valid        = pipe.vld[pmac_pkg::NSTG-1];
  assign out_bus.scaled_delta = scaled;
  assign out_bus.status       = st;

endmodule

`default_nettype wire

// ===== sv/pmac_cfg.sv =====
// pmac_cfg: apb register file and the settings derived from it
// depends on pmac_pkg
`default_nettype none

module pmac_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pmac_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output pmac_pkg::cfg_t                  cfg
);

  pmac_pkg::sens_t      base_r;
  pmac_pkg::sens_t      adj_r;
  pmac_pkg::fac_t       maxf_r;
  pmac_pkg::mode_t      mode_r;
  pmac_pkg::reg_idx_t   idx;
  logic                 wr;
  logic [16:0]          maxf_c;

  assign pready = 1'b1;
  assign idx    = pmac_pkg::reg_idx_t'(paddr[pmac_pkg::ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= pmac_pkg::sens_t'(1000);
      adj_r  <= pmac_pkg::sens_t'(1000);
      maxf_r <= pmac_pkg::fac_t'(1500);
      mode_r <= pmac_pkg::MODE_MILD;
    end else if (wr) begin
      case (idx)
        pmac_pkg::REG_BASE_SENS: base_r <= pwdata[15:0];
        pmac_pkg::REG_ADJ_SENS:  adj_r  <= pwdata[15:0];
        pmac_pkg::REG_MAX_FAC:   maxf_r <= pwdata[15:0];
        pmac_pkg::REG_MODE:      mode_r <= pmac_pkg::mode_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pmac_pkg::REG_BASE_SENS: prdata = {16'd0, base_r};
      pmac_pkg::REG_ADJ_SENS:  prdata = {16'd0, adj_r};
      pmac_pkg::REG_MAX_FAC:   prdata = {16'd0, maxf_r};
      pmac_pkg::REG_MODE:      prdata = {30'd0, mode_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // factor cap clamped to scale..factor limit
  always_comb begin
    if (int'(maxf_r) < pmac_pkg::SCALE) begin
      maxf_c = 17'(pmac_pkg::SCALE);
    end else if (int'(maxf_r) > pmac_pkg::FACTOR_LIMIT) begin
      maxf_c = 17'(pmac_pkg::FACTOR_LIMIT);
    end else begin
      maxf_c = {1'b0, maxf_r};
    end
    cfg.bad = (base_r == '0) || (int'(base_r) > pmac_pkg::SENS_LIMIT) ||
              (adj_r == '0) || (int'(adj_r) > pmac_pkg::SENS_LIMIT);
    cfg.adj = adj_r;
    cfg.max_add = (int'(maxf_c) > pmac_pkg::SCALE) ?
                  pmac_pkg::fac_t'(maxf_c - 17'(pmac_pkg::SCALE)) : '0;
    cfg.mode = (mode_r == pmac_pkg::MODE_ALT) ? pmac_pkg::MODE_MILD : mode_r;
  end

endmodule

`default_nettype wire

// ===== sv/pmac_ctl.sv =====
// pmac_ctl: valid bits and per-stage load enables of the pipeline
// depends on pmac_pkg
`default_nettype none

module pmac_ctl (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      out_ready,
  output pmac_pkg::pipe_t pipe
);

  logic [pmac_pkg::NSTG-1:0] vld_r;
  logic [pmac_pkg::NSTG-1:0] vld_nxt;
  logic [pmac_pkg::NSTG-1:0] rdy;
  logic [pmac_pkg::NSTG-1:0] vin;

  // a stage loads when empty or when the one after it moves on
  always_comb begin
    rdy[pmac_pkg::NSTG-1] = !vld_r[pmac_pkg::NSTG-1] | out_ready;
    for (int k = pmac_pkg::NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] | rdy[k+1];
    end
    vin     = {vld_r[pmac_pkg::NSTG-2:0], in_valid};
    vld_nxt = (rdy & vin) | (~rdy & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign pipe.en  = rdy;
  assign pipe.vld = vld_r;

endmodule

`default_nettype wire

// ===== sv/pmac_divsc.sv =====
// pmac_divsc: two-stage divide by scale, reciprocal multiply then one correction
// depends on pmac_pkg
`default_nettype none

module pmac_divsc (
  input  wire logic           clk,
  input  wire logic           ld_a,
  input  wire logic           ld_b,
  input  wire pmac_pkg::sat_t num,
  output pmac_pkg::quo_t      quo
);

  pmac_pkg::sat_t  num_r;
  pmac_pkg::quo_t  q0_r;
  pmac_pkg::quo_t  quo_r;
  pmac_pkg::divp_t prod;
  pmac_pkg::sat_t  rem;
  pmac_pkg::quo_t  quo_nxt;

  assign prod = pmac_pkg::divp_t'(num) * pmac_pkg::divp_t'(pmac_pkg::DIV_RECIP);

  // estimate is low by at most one
  always_comb begin
    rem     = num_r - pmac_pkg::sat_t'(q0_r) * pmac_pkg::sat_t'(pmac_pkg::SCALE);
    quo_nxt = q0_r + pmac_pkg::quo_t'(int'(rem) >= pmac_pkg::SCALE);
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      num_r <= num;
      q0_r  <= pmac_pkg::quo_t'(prod >> pmac_pkg::DIV_SHIFT);
    end
    if (ld_b) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

// ===== sv/pmac_dp.sv =====
// pmac_dp: nine-stage datapath from raw delta to scaled delta and status
// depends on pmac_pkg and pmac_divsc
`default_nettype none

module pmac_dp (
  input  wire logic            clk,
  input  wire pmac_pkg::pipe_t pipe,
  input  wire pmac_pkg::cfg_t  cfg,
  input  wire pmac_pkg::d16_t  motion_delta,
  output pmac_pkg::d16_t       scaled_delta,
  output pmac_pkg::status_t    status
);

  pmac_pkg::side_t   side_r [0:pmac_pkg::NSTG-2];
  pmac_pkg::side_t   side_in [0:pmac_pkg::NSTG-2];
  pmac_pkg::side_t   side0_nxt;
  logic [16:0]       xe;
  logic [16:0]       a17;
  logic              clmp;

  pmac_pkg::prod_t   m1_r;
  pmac_pkg::sq_t     sq1_r;
  pmac_pkg::sq_t     sq2_r;
  pmac_pkg::sq_t     d0_2_r;
  pmac_pkg::sq_t     add3_r;
  pmac_pkg::fac_t    cf4_r;
  pmac_pkg::cp_t     p5_r;
  pmac_pkg::d16_t    scaled_r;
  pmac_pkg::status_t status_r;

  pmac_pkg::sat_t    m_sat;
  pmac_pkg::tenp_t   tp;
  pmac_pkg::sq_t     rem10;
  pmac_pkg::sq_t     mild;
  pmac_pkg::sq_t     add3_nxt;
  pmac_pkg::fac_t    add_c;
  logic              on_nxt;
  pmac_pkg::sat_t    p_sat;
  pmac_pkg::quo_t    q1;
  pmac_pkg::quo_t    q2;
  pmac_pkg::side_t   s7;
  pmac_pkg::quo_t    r;
  pmac_pkg::d16_t    rv;
  pmac_pkg::d16_t    mv;
  pmac_pkg::d16_t    scaled_nxt;

  // stage 0: magnitude, reject and clamp
  always_comb begin
    xe   = {motion_delta[15], motion_delta};
    a17  = motion_delta[15] ? (~xe + 17'd1) : xe;
    clmp = int'(a17) > pmac_pkg::REASONABLE_LIMIT;
    side0_nxt     = '0;
    side0_nxt.neg = motion_delta[15];
    side0_nxt.mag = clmp ? pmac_pkg::mag_t'(pmac_pkg::REASONABLE_LIMIT)
                         : pmac_pkg::mag_t'(a17);
    side0_nxt.cw  = (side0_nxt.mag > pmac_pkg::mag_t'(1)) &&
                    (int'(side0_nxt.mag) <= pmac_pkg::CURVE_INPUT_LIMIT);
    if (int'(a17) > pmac_pkg::EXTREME_LIMIT) begin
      side0_nxt.st = pmac_pkg::ST_EXTREME;
    end else if (cfg.bad) begin
      side0_nxt.st = pmac_pkg::ST_PASS;
    end else if (clmp) begin
      side0_nxt.st = pmac_pkg::ST_CLAMP;
    end else begin
      side0_nxt.st = pmac_pkg::ST_NORMAL;
    end
  end

  // stage 2: saturate product, estimate square over ten
  always_comb begin
    m_sat = (m1_r > pmac_pkg::prod_t'(pmac_pkg::SAT_LIM)) ?
            pmac_pkg::sat_t'(pmac_pkg::SAT_LIM) : pmac_pkg::sat_t'(m1_r);
    tp    = pmac_pkg::tenp_t'(sq1_r) * pmac_pkg::tenp_t'(pmac_pkg::TEN_RECIP);
  end

  // stage 3: correct square over ten, pick curve addition
  always_comb begin
    rem10 = sq2_r - d0_2_r * pmac_pkg::sq_t'(pmac_pkg::MILD_DEN);
    mild  = d0_2_r + pmac_pkg::sq_t'(int'(rem10) >= pmac_pkg::MILD_DEN);
    case (cfg.mode)
      pmac_pkg::MODE_LIN:
        add3_nxt = pmac_pkg::sq_t'(side_r[2].mag) * pmac_pkg::sq_t'(pmac_pkg::LIN_STEP);
      pmac_pkg::MODE_STRONG:
        add3_nxt = sq2_r >> pmac_pkg::STRONG_SHIFT;
      default:
        add3_nxt = mild;
    endcase
  end

  // stage 4: cap addition, form curve factor
  always_comb begin
    add_c  = (add3_r > pmac_pkg::sq_t'(cfg.max_add)) ? cfg.max_add
                                                     : pmac_pkg::fac_t'(add3_r);
    on_nxt = side_r[3].cw && (add_c != '0);
  end

  // side data entering each stage
  always_comb begin
    side_in[0] = side0_nxt;
    for (int k = 1; k < pmac_pkg::NSTG - 1; k++) begin
      side_in[k] = side_r[k-1];
    end
    side_in[2].half = int'(m1_r) >= pmac_pkg::HALF_SCALE;
    side_in[4].on   = on_nxt;
    side_in[4].res  = q1;
  end

  // stage 6: saturate curve product
  assign p_sat = (p5_r > pmac_pkg::cp_t'(pmac_pkg::SAT_LIM)) ?
                 pmac_pkg::sat_t'(pmac_pkg::SAT_LIM) : pmac_pkg::sat_t'(p5_r);

  pmac_divsc u_div_sens (
    .clk  (clk),
    .ld_a (pipe.en[2]),
    .ld_b (pipe.en[3]),
    .num  (m_sat),
    .quo  (q1)
  );

  pmac_divsc u_div_curve (
    .clk  (clk),
    .ld_a (pipe.en[6]),
    .ld_b (pipe.en[7]),
    .num  (p_sat),
    .quo  (q2)
  );

  // stage 8: minimum movement, sanity fallback, sign and status
  always_comb begin
    s7 = side_r[pmac_pkg::NSTG-2];
    r  = s7.on ? q2 : s7.res;
    if ((s7.mag != '0) && (r == '0) && s7.half) begin
      r = pmac_pkg::quo_t'(1);
    end
    if ((int'(s7.mag) <= pmac_pkg::SANE_IN) && (int'(r) > pmac_pkg::SANE_OUT)) begin
      r = pmac_pkg::quo_t'({s7.mag, 1'b0});
    end
    rv = pmac_pkg::d16_t'(r);
    mv = pmac_pkg::d16_t'(s7.mag);
    case (s7.st)
      pmac_pkg::ST_EXTREME: scaled_nxt = '0;
      pmac_pkg::ST_PASS:    scaled_nxt = s7.neg ? (16'd0 - mv) : mv;
      default:              scaled_nxt = s7.neg ? (16'd0 - rv) : rv;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < pmac_pkg::NSTG - 1; k++) begin
      if (pipe.en[k]) begin
        side_r[k] <= side_in[k];
      end
    end
    if (pipe.en[1]) begin
      m1_r  <= pmac_pkg::prod_t'(side_r[0].mag) * pmac_pkg::prod_t'(cfg.adj);
      sq1_r <= pmac_pkg::sq_t'(side_r[0].mag) * pmac_pkg::sq_t'(side_r[0].mag);
    end
    if (pipe.en[2]) begin
      sq2_r  <= sq1_r;
      d0_2_r <= pmac_pkg::sq_t'(tp >> pmac_pkg::TEN_SHIFT);
    end
    if (pipe.en[3]) begin
      add3_r <= add3_nxt;
    end
    if (pipe.en[4]) begin
      cf4_r <= pmac_pkg::fac_t'(pmac_pkg::SCALE) + add_c;
    end
    if (pipe.en[5]) begin
      p5_r <= pmac_pkg::cp_t'(side_r[4].res) * pmac_pkg::cp_t'(cf4_r);
    end
    if (pipe.en[pmac_pkg::NSTG-1]) begin
      scaled_r <= scaled_nxt;
      status_r <= s7.st;
    end
  end

  assign scaled_delta = scaled_r;
  assign status       = status_r;

endmodule

`default_nettype wire
